/* hw/rtl/sha256_pkg.sv */
package sha256_pkg;

	// input and result words
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last_byte;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_word_t;

	// eight working or chaining words, element 0 is a / h0
	typedef logic [7:0][31:0] hash_arr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	// control toward the round unit
	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

	// control toward the block buffer / schedule
	typedef struct packed {
		logic       shift;
		logic [7:0] byte_val;
		logic       step;
	} sched_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_RND = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd7;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned amt);
		return (x >> amt) | (x << (32 - amt));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* hw/rtl/sha256_message_hasher.sv */
// a word that does not fill a block is only stored in the block buffer; a word that fills
// the 64-byte block starts a compression (1 load, 64 rounds on the shared round unit, 1 add)
// last word: padding goes in at one byte per cycle, then each padded block is compressed
// (64 rounds, 1 add; one or two blocks), then 8 digest words, one per cycle while dig_ready is high
// throughput: one message word at a time, msg_ready is high only in the idle state
// reset: arst_n clears control state and loads the initial hash and a zero bit count
module sha256_message_hasher (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_ready,
	input  sha256_pkg::msg_word_t msg_word,
	output logic                  dig_valid,
	input  logic                  dig_ready,
	output sha256_pkg::dig_word_t dig_word
);

	sha256_pkg::state_t     state_q;
	sha256_pkg::state_t     state_nxt;
	sha256_pkg::hash_arr_t  cv_q;
	sha256_pkg::hash_arr_t  v;
	sha256_pkg::round_ctl_t rctl;
	sha256_pkg::sched_ctl_t sctl;
	logic [63:0] bit_cnt_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_idx_q;
	logic        last_pend_q;
	logic        pad_mode_q;
	logic        sent80_q;
	logic        final_blk_q;
	logic        msg_acc;
	logic        dig_acc;
	logic [7:0]  pad_byte;
	logic [31:0] w_cur;

	assign msg_acc = msg_valid && msg_ready;
	assign dig_acc = dig_valid && dig_ready;

	sha256_sched u_sched (
		.clk   (clk),
		.ctl   (sctl),
		.w_cur (w_cur)
	);

	sha256_round u_round (
		.clk (clk),
		.ctl (rctl),
		.cv  (cv_q),
		.k   (sha256_pkg::RND_K[rnd_q]),
		.w   (w_cur),
		.v   (v)
	);

	// padding byte: marker, zero fill, or big-endian length in the final block
	always_comb begin
		if (!sent80_q) begin
			pad_byte = sha256_pkg::PAD_BYTE;
		end else if (final_blk_q && fill_q >= sha256_pkg::LEN_POS) begin
			pad_byte = bit_cnt_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = '0;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (msg_valid) begin
					if (msg_word.byte_present && fill_q == sha256_pkg::LAST_POS) begin
						state_nxt = sha256_pkg::ST_COMP;
					end else if (msg_word.last_byte) begin
						state_nxt = sha256_pkg::ST_PAD;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				if (fill_q == sha256_pkg::LAST_POS) begin
					state_nxt = sha256_pkg::ST_COMP;
				end
			end
			sha256_pkg::ST_COMP: begin
				if (rnd_q == sha256_pkg::LAST_RND) begin
					state_nxt = sha256_pkg::ST_FIN;
				end
			end
			sha256_pkg::ST_FIN: begin
				if (pad_mode_q) begin
					state_nxt = final_blk_q ? sha256_pkg::ST_OUT : sha256_pkg::ST_PAD;
				end else begin
					state_nxt = last_pend_q ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
				end
			end
			sha256_pkg::ST_OUT: begin
				if (dig_ready && out_idx_q == sha256_pkg::LAST_IDX) begin
					state_nxt = sha256_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sha256_pkg::ST_IDLE;
		endcase
	end

	// outputs and unit control
	always_comb begin
		msg_ready = (state_q == sha256_pkg::ST_IDLE);
		dig_valid = (state_q == sha256_pkg::ST_OUT);
		sctl.shift = (msg_acc && msg_word.byte_present) || (state_q == sha256_pkg::ST_PAD);
		sctl.byte_val = (state_q == sha256_pkg::ST_PAD) ? pad_byte : msg_word.data_byte;
		sctl.step = (state_q == sha256_pkg::ST_COMP);
		rctl.load = sctl.shift && fill_q == sha256_pkg::LAST_POS;
		rctl.step = (state_q == sha256_pkg::ST_COMP);
		dig_word.digest_word = cv_q[out_idx_q];
		dig_word.word_index = out_idx_q;
		dig_word.last_word = (out_idx_q == sha256_pkg::LAST_IDX);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// message bookkeeping, chaining value and output index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= sha256_pkg::IV[i];
			end
			bit_cnt_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			out_idx_q <= '0;
			last_pend_q <= 1'b0;
			pad_mode_q <= 1'b0;
			sent80_q <= 1'b0;
			final_blk_q <= 1'b0;
		end else begin
			unique case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (msg_acc) begin
						last_pend_q <= msg_word.last_byte;
						if (msg_word.byte_present) begin
							bit_cnt_q <= bit_cnt_q + 64'd8;
							fill_q <= fill_q + 6'd1;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					pad_mode_q <= 1'b1;
					fill_q <= fill_q + 6'd1;
					if (!sent80_q) begin
						sent80_q <= 1'b1;
						final_blk_q <= (fill_q < sha256_pkg::LEN_POS);
					end
				end
				sha256_pkg::ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
				end
				sha256_pkg::ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						cv_q[i] <= cv_q[i] + v[i];
					end
					if (pad_mode_q) begin
						final_blk_q <= 1'b1;
					end
				end
				sha256_pkg::ST_OUT: begin
					if (dig_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == sha256_pkg::LAST_IDX) begin
							for (int i = 0; i < 8; i++) begin
								cv_q[i] <= sha256_pkg::IV[i];
							end
							bit_cnt_q <= '0;
							fill_q <= '0;
							last_pend_q <= 1'b0;
							pad_mode_q <= 1'b0;
							sent80_q <= 1'b0;
							final_blk_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/sha256_sched.sv */
module sha256_sched (
	input  logic                   clk,
	input  sha256_pkg::sched_ctl_t ctl,
	output logic [31:0]            w_cur
);

	// 64-byte block buffer, doubles as the 16-word schedule window
	logic [0:15][31:0] win_q;
	logic [511:0]      flat;
	logic [31:0]       w_new;

	assign flat = win_q;
	assign w_cur = win_q[0];

	// next schedule word from the window taps
	assign w_new = win_q[0] + sha256_pkg::sml_sig0(win_q[1]) + win_q[9]
		+ sha256_pkg::sml_sig1(win_q[14]);

	// bytes shift in big-endian; rounds shift out one word each
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= {flat[503:0], ctl.byte_val};
		end else if (ctl.step) begin
			win_q <= {flat[479:0], w_new};
		end
	end

endmodule

/* hw/rtl/sha256_round.sv */
module sha256_round (
	input  logic                   clk,
	input  sha256_pkg::round_ctl_t ctl,
	input  sha256_pkg::hash_arr_t  cv,
	input  logic [31:0]            k,
	input  logic [31:0]            w,
	output sha256_pkg::hash_arr_t  v
);

	sha256_pkg::hash_arr_t v_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign v = v_q;

	// one compression round
	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + sha256_pkg::big_sig1(v_q[4]) + ch + k + w;
		t2 = sha256_pkg::big_sig0(v_q[0]) + maj;
	end

	// working variables a..h
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= cv;
		end else if (ctl.step) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

endmodule

/* hw/rtl/sha256_checker.sv */
module sha256_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  msg_valid,
	input logic                  msg_ready,
	input logic                  dig_valid,
	input logic                  dig_ready,
	input sha256_pkg::dig_word_t dig_word
);

	// no new message word while the digest is going out
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready |-> !dig_valid)
		else $error("message word accepted during digest output");

	// digest words follow in order
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !dig_word.last_word |=>
		dig_valid && dig_word.word_index == 3'($past(dig_word.word_index) + 3'd1))
		else $error("digest word index out of sequence");

	// the last flag sits on word seven only
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> dig_word.last_word == (dig_word.word_index == 3'd7))
		else $error("last word flag does not match index");

	// output closes after the last word
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && dig_word.last_word |=> !dig_valid)
		else $error("digest output continues after last word");

	// a stalled digest word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig_word))
		else $error("stalled digest word changed");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg_valid),
	.msg_ready (msg_ready),
	.dig_valid (dig_valid),
	.dig_ready (dig_ready),
	.dig_word  (dig_word)
);

/* sim/sha256_message_hasher_tb.sv */
module sha256_message_hasher_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS = 320;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// digests of the empty message and of "abc"
	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// directed rows; a digest is typed in only where it is well known
	typedef struct packed {
		sha256_pkg::msg_word_t word;
		logic                  known;
		logic [255:0]          digest;
	} stim_row_t;

	localparam int DIR_ROWS = 13;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// empty message
		'{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
		// empty word mid-stream, then "abc" with a second empty word inside
		'{'{8'h00, 1'b0, 1'b0}, 1'b0, 256'h0},
		'{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
		'{'{8'hff, 1'b0, 1'b0}, 1'b0, 256'h0},
		'{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
		'{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
		// byte extremes, closed by an empty final word
		'{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
		'{'{8'h00, 1'b1, 1'b0}, 1'b0, 256'h0},
		'{'{8'h80, 1'b1, 1'b0}, 1'b0, 256'h0},
		'{'{8'h7f, 1'b0, 1'b1}, 1'b0, 256'h0},
		// one-byte messages with the byte on the final word
		'{'{8'h80, 1'b1, 1'b1}, 1'b0, 256'h0},
		'{'{8'hff, 1'b1, 1'b1}, 1'b0, 256'h0},
		'{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0}
	};

	localparam int EDGE_LEN_CNT = 13;
	localparam int BLOCK_EDGE_LEN [EDGE_LEN_CNT] = '{
		54, 55, 56, 57, 62, 63, 64, 65, 118, 119, 120, 127, 128
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  msg_valid = 1'b0;
	logic                  msg_ready;
	sha256_pkg::msg_word_t msg_word = '0;
	logic                  dig_valid;
	logic                  dig_ready = 1'b0;
	sha256_pkg::dig_word_t dig_word;

	// hash state of the predictor
	logic [31:0] chain_h [8];
	logic [31:0] blk_w [16];
	logic [63:0] bit_len;

	sha256_pkg::dig_word_t digest_q [$];
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        fail_cnt = 0;
	int        words_checked = 0;
	int        msgs_hashed = 0;
	int        longest_msg = 0;

	sha256_message_hasher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_word  (msg_word),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig_word  (dig_word)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	function automatic void reset_chain();
		for (int i = 0; i < 8; i++) chain_h[i] = HASH_INIT[i];
		for (int i = 0; i < 16; i++) blk_w[i] = '0;
		bit_len = '0;
	endfunction

	function automatic void put_msg_byte(input int pos, input logic [7:0] val);
		blk_w[pos / 4][(3 - pos % 4) * 8 +: 8] = val;
	endfunction

	// one 64-round compression of blk_w into chain_h
	function automatic void compress_block();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, ch, maj;
		for (int t = 0; t < 16; t++) sched[t] = blk_w[t];
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
			s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
			sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = chain_h[i];
		for (int t = 0; t < 64; t++) begin
			s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + ROUND_K[t] + sched[t];
			s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
	endfunction

	// absorb one word; returns 1 with the digest when the message ends
	function automatic bit hash_item(input sha256_pkg::msg_word_t w,
		output logic [255:0] dig);
		int pos;
		dig = '0;
		if (w.byte_present) begin
			pos = int'(bit_len[8:3]);
			put_msg_byte(pos, w.data_byte);
			bit_len = bit_len + 64'd8;
			if (pos == 63) compress_block();
		end
		if (!w.last_byte) return 1'b0;
		// padding, spilling into a second block past byte 55
		pos = int'(bit_len[8:3]);
		put_msg_byte(pos, PAD_MARK);
		for (int i = pos + 1; i < 64; i++) put_msg_byte(i, 8'h00);
		if (pos >= 56) begin
			compress_block();
			for (int i = 0; i < 16; i++) blk_w[i] = '0;
		end
		blk_w[14] = bit_len[63:32];
		blk_w[15] = bit_len[31:0];
		compress_block();
		for (int i = 0; i < 8; i++) dig[255 - 32 * i -: 32] = chain_h[i];
		reset_chain();
		return 1'b1;
	endfunction

	// drive one word, wait for acceptance, then queue the digest it completes
	task automatic push_word(input sha256_pkg::msg_word_t w, input logic known,
		input logic [255:0] typed);
		logic [255:0]          dig;
		sha256_pkg::dig_word_t exp_w;
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid <= 1'b1;
		msg_word <= w;
		@(posedge clk);
		while (!msg_ready) @(posedge clk);
		if (hash_item(w, dig)) begin
			if (known) dig = typed;
			for (int i = 0; i < 8; i++) begin
				exp_w.digest_word = dig[255 - 32 * i -: 32];
				exp_w.word_index = 3'(i);
				exp_w.last_word = (i == 7);
				digest_q.push_back(exp_w);
			end
			msgs_hashed++;
		end
		@(negedge clk);
	endtask

	// random message: mostly block-edge or short lengths, with empty words mixed in
	task automatic send_rand_msg(output int sent);
		int                    len;
		int                    pick;
		bit                    byte_on_last;
		sha256_pkg::msg_word_t w;
		pick = $urandom_range(9);
		if (pick < 4) len = $urandom_range(8);
		else if (pick < 8) len = BLOCK_EDGE_LEN[$urandom_range(EDGE_LEN_CNT - 1)];
		else len = $urandom_range(140);
		byte_on_last = (len > 0) && ($urandom_range(1) == 1);
		if (len > longest_msg) longest_msg = len;
		sent = 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8) begin
				w.data_byte = 8'($urandom);
				w.byte_present = 1'b0;
				w.last_byte = 1'b0;
				push_word(w, 1'b0, '0);
				sent++;
			end
			w.data_byte = 8'($urandom);
			w.byte_present = 1'b1;
			w.last_byte = byte_on_last && (i == len - 1);
			push_word(w, 1'b0, '0);
			sent++;
		end
		if (!byte_on_last) begin
			w.data_byte = 8'($urandom);
			w.byte_present = 1'b0;
			w.last_byte = 1'b1;
			push_word(w, 1'b0, '0);
			sent++;
		end
	endtask

	// receiver stalls
	initial begin
		forever begin
			@(negedge clk);
			dig_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each digest word with the oldest expectation
	always @(posedge clk) begin : dig_check
		sha256_pkg::dig_word_t exp_w;
		if (arst_n && dig_valid && dig_ready) begin
			if (digest_q.size() == 0) begin
				$error("digest word %h with no expectation", dig_word.digest_word);
				fail_cnt++;
			end else begin
				exp_w = digest_q.pop_front();
				words_checked++;
				if (dig_word.digest_word !== exp_w.digest_word) begin
					$error("digest_word: expected %h, actual %h",
						exp_w.digest_word, dig_word.digest_word);
					fail_cnt++;
				end
				if (dig_word.word_index !== exp_w.word_index) begin
					$error("word_index: expected %0d, actual %0d",
						exp_w.word_index, dig_word.word_index);
					fail_cnt++;
				end
				if (dig_word.last_word !== exp_w.last_word) begin
					$error("last_word: expected %b, actual %b",
						exp_w.last_word, dig_word.last_word);
					fail_cnt++;
				end
			end
		end
	end

	// main sequence
	initial begin
		int rand_sent;
		int n;
		reset_chain();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 63;
		for (int r = 0; r < DIR_ROWS; r++) begin
			push_word(DIR_TABLE[r].word, DIR_TABLE[r].known, DIR_TABLE[r].digest);
		end

		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			if (rand_sent >= 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (rand_sent >= RAND_ITEMS / 3) begin
				send_idle_pct = 63;
				recv_idle_pct = 36;
			end
			send_rand_msg(n);
			rand_sent += n;
		end
		msg_valid <= 1'b0;

		// drain, then watch for stray words
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("hashed %0d messages (%0d table rows, %0d random words, longest %0d bytes)",
			msgs_hashed, DIR_ROWS, rand_sent, longest_msg);
		$display("checked %0d digest words under three stall patterns", words_checked);
		if (fail_cnt == 0 && digest_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_sched.sv
hw/rtl/sha256_round.sv
hw/rtl/sha256_message_hasher.sv
hw/rtl/sha256_checker.sv
sim/sha256_message_hasher_tb.sv
